### src/ilo_pkg.sv
// Package for the index list odometer: sizes, request and status codes,
// and the command struct and packed vector types shared by the modules.
// No dependencies.
package ilo_pkg;

    localparam int MAX_DIMS    = 8;
    localparam int MAX_LIST    = 64;
    localparam int VALUE_WIDTH = 32;

    localparam int DIM_W  = $clog2(MAX_DIMS);
    localparam int CNT_W  = $clog2(MAX_DIMS + 1);
    localparam int POS_W  = $clog2(MAX_LIST);
    localparam int LEN_W  = $clog2(MAX_LIST + 1);
    localparam int ADDR_W = DIM_W + POS_W;
    localparam int DEPTH  = MAX_DIMS * MAX_LIST;

    typedef enum logic [2:0] {
        REQ_CLEAR      = 3'd0,
        REQ_APPEND     = 3'd1,
        REQ_START      = 3'd2,
        REQ_ADVANCE    = 3'd3,
        REQ_READ_CUR   = 3'd4,
        REQ_READ_ENTRY = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic clear;
        logic start;
        logic advance;
    } odo_cmd_t;

    typedef logic [MAX_DIMS-1:0][LEN_W-1:0] len_vec_t;
    typedef logic [MAX_DIMS-1:0][POS_W-1:0] pos_vec_t;

endpackage

### src/ilo_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ilo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/ilo_odometer.sv
// Position counters of the odometer with carry toward dimension 0, the
// started dimension count and the sticky done flag. Depends on ilo_pkg.
module ilo_odometer
    import ilo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  odo_cmd_t         cmd,
    input  logic [CNT_W-1:0] stored_dims,
    input  len_vec_t         lengths,
    output pos_vec_t         positions,
    output logic [CNT_W-1:0] started_dims,
    output logic             done
);

    pos_vec_t         pos_reg, pos_next;
    logic [CNT_W-1:0] started_reg, started_next;
    logic             done_reg, done_next;
    logic             carry;
    logic [LEN_W-1:0] inc;

    always_comb
    begin
        pos_next     = pos_reg;
        started_next = started_reg;
        done_next    = done_reg;
        carry        = 1'b1;
        inc          = '0;
        if (cmd.clear)
        begin
            pos_next     = '0;
            started_next = '0;
            done_next    = 1'b1;
        end
        else if (cmd.start)
        begin
            pos_next     = '0;
            started_next = stored_dims;
            done_next    = 1'b0;
        end
        else if (cmd.advance)
        begin
            if (started_reg == '0)
            begin
                done_next = 1'b1;
            end
            else
            begin
                // Innermost active dimension first; the carry ripples outward.
                for (int i = MAX_DIMS - 1; i >= 0; i--)
                begin
                    if ((CNT_W'(i) < started_reg) && carry)
                    begin
                        inc = LEN_W'(pos_reg[i]) + LEN_W'(1);
                        if (inc < lengths[i])
                        begin
                            pos_next[i] = POS_W'(inc);
                            carry       = 1'b0;
                        end
                        else
                        begin
                            pos_next[i] = '0;
                        end
                    end
                end
                if (carry)
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            started_reg <= '0;
            done_reg    <= 1'b1;
        end
        else
        begin
            pos_reg     <= pos_next;
            started_reg <= started_next;
            done_reg    <= done_next;
        end
    end

    assign positions    = pos_reg;
    assign started_dims = started_reg;
    assign done         = done_reg;

endmodule

### src/index_list_odometer_top.sv
// Top level of the index list odometer: request decode, list lengths and the entry table.
// The result word is valid in the cycle after the request word is taken.
// The next request is taken only once the previous result word has been taken.
// Reset (async, active low) empties all lists and ends the enumeration with done set;
// table contents are not cleared. Depends on ilo_pkg, ilo_ram and ilo_odometer.
module index_list_odometer_top
    import ilo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [2:0]         dim,
    input  logic [5:0]         pos,
    input  logic signed [31:0] value,
    input  logic               last_in_list,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] index_value,
    output logic               done_res,
    output logic [3:0]         active_dims,
    output logic [6:0]         list_length,
    output logic [1:0]         status
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_OUT  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    len_vec_t         lengths_reg, lengths_next;
    logic [CNT_W-1:0] stored_reg, stored_next;
    logic [LEN_W-1:0] pending_reg, pending_next;
    logic [LEN_W-1:0] out_len_reg, out_len_next;
    status_t          out_status_reg, out_status_next;
    logic             from_ram_reg, from_ram_next;

    logic                   accept;
    odo_cmd_t               cmd;
    pos_vec_t               positions;
    logic [CNT_W-1:0]       started_dims;
    logic                   done;
    logic                   wr_en, rd_en;
    logic [ADDR_W-1:0]      wr_addr, rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic [LEN_W-1:0]       len_sel, pend_inc;
    logic                   list_full;

    assign accept    = in_valid && in_ready;
    assign len_sel   = lengths_reg[dim];
    assign pend_inc  = pending_reg + LEN_W'(1);
    assign list_full = pending_reg >= LEN_W'(MAX_LIST);
    assign wr_addr   = {stored_reg[DIM_W-1:0], pending_reg[POS_W-1:0]};

    always_comb
    begin
        state_next      = state_reg;
        lengths_next    = lengths_reg;
        stored_next     = stored_reg;
        pending_next    = pending_reg;
        out_len_next    = out_len_reg;
        out_status_next = out_status_reg;
        from_ram_next   = from_ram_reg;
        cmd             = '0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next      = S_OUT;
                    out_len_next    = '0;
                    out_status_next = ST_OK;
                    from_ram_next   = 1'b0;
                    unique case (req_t'(req_type))
                        REQ_CLEAR:
                        begin
                            lengths_next = '0;
                            stored_next  = '0;
                            pending_next = '0;
                            cmd.clear    = 1'b1;
                        end
                        REQ_APPEND:
                        begin
                            if (stored_reg >= CNT_W'(MAX_DIMS))
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                if (!list_full)
                                begin
                                    wr_en = 1'b1;
                                end
                                else
                                begin
                                    out_status_next = ST_FULL;
                                end
                                if (last_in_list)
                                begin
                                    lengths_next[stored_reg[DIM_W-1:0]] =
                                        list_full ? pending_reg : pend_inc;
                                    stored_next  = stored_reg + CNT_W'(1);
                                    pending_next = '0;
                                end
                                else if (!list_full)
                                begin
                                    pending_next = pend_inc;
                                end
                            end
                        end
                        REQ_START:
                        begin
                            cmd.start = 1'b1;
                        end
                        REQ_ADVANCE:
                        begin
                            cmd.advance = 1'b1;
                        end
                        REQ_READ_CUR:
                        begin
                            out_len_next = len_sel;
                            if (CNT_W'(dim) >= started_dims)
                            begin
                                out_status_next = ST_RANGE;
                            end
                            else
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = {dim, positions[dim]};
                                from_ram_next = 1'b1;
                            end
                        end
                        REQ_READ_ENTRY:
                        begin
                            out_len_next = len_sel;
                            if ((CNT_W'(dim) >= stored_reg) || (LEN_W'(pos) >= len_sel))
                            begin
                                out_status_next = ST_RANGE;
                            end
                            else
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = {dim, pos};
                                from_ram_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_RANGE;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            lengths_reg  <= '0;
            stored_reg   <= '0;
            pending_reg  <= '0;
            from_ram_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lengths_reg  <= lengths_next;
            stored_reg   <= stored_next;
            pending_reg  <= pending_next;
            from_ram_reg <= from_ram_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_len_reg    <= out_len_next;
        out_status_reg <= out_status_next;
    end

    ilo_odometer u_odometer (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stored_dims  (stored_reg),
        .lengths      (lengths_reg),
        .positions    (positions),
        .started_dims (started_dims),
        .done         (done)
    );

    ilo_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value[VALUE_WIDTH-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The read word holds in the RAM output until the next read request is taken.
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign index_value = from_ram_reg ? 32'($signed(rd_data)) : '0;
    assign done_res    = done;
    assign active_dims = 4'(started_dims);
    assign list_length = 7'(out_len_reg);
    assign status      = out_status_reg;

endmodule
